// File: design/ibd_pkg.sv
// Shared types, constants and register codes for the image box downscaler.
`timescale 1ns / 1ps

package ibd_pkg;

  localparam int MaxWidth   = 2048;
  localparam int StoreDepth = MaxWidth / 2;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int BlkW       = $clog2(StoreDepth);
  localparam int WidthW     = 12;
  localparam int PixW       = 16;
  localparam int SumW       = 20;
  localparam int CntW       = 5;
  localparam int DivSteps   = SumW;
  localparam int StepW      = $clog2(DivSteps);
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = WidthW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegScale = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDepth = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWidth = 2'd2;

  // scale codes
  localparam logic [1:0] ScaleNone = 2'd0;
  localparam logic [1:0] Scale2x2  = 2'd1;
  localparam logic [1:0] Scale4x4  = 2'd2;

  localparam logic [WidthW-1:0] WidthReset = 12'd640;

  typedef struct packed {
    logic [PixW-1:0] pixel_value;
    logic            frame_end;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] binned_value;
    logic            row_end;
    logic            frame_done;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic calc;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pass;
    logic emit;
    logic need_div;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/ibd_datapath.sv
// Datapath: config registers, band line store, accumulator, divider, output register.
`timescale 1ns / 1ps

module ibd_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ibd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ibd_pkg::CfgDataW-1:0] cfg_data_i,
  input  ibd_pkg::in_item_t            in_item_i,
  input  ibd_pkg::dp_cmd_t             cmd_i,
  output ibd_pkg::dp_stat_t            stat_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output ibd_pkg::out_item_t           out_item_o
);
  import ibd_pkg::*;

  // configuration
  logic [1:0]        scale_q;
  logic              depth_q;
  logic [WidthW-1:0] width_q;

  // position counters
  logic [ColW-1:0] col_q, col_d;
  logic [1:0]      row_q, row_d;

  // item under work
  logic [PixW-1:0] v_q;
  logic            fend_q;
  logic            first_q;
  logic            emit_q;
  logic            row_end_q;
  logic [BlkW-1:0] blk_q;
  logic [PixW-1:0] res_q;

  // divider
  logic [SumW-1:0] num_q;
  logic [CntW-1:0] rem_q;
  logic [CntW-1:0] den_q;

  // line store
  logic [SumW+CntW-1:0] mem [StoreDepth];
  logic [SumW+CntW-1:0] rd_q;

  logic                 out_valid_q;
  out_item_t            out_item_q;

  logic [WidthW-1:0] eff_w;
  logic              is2, is4, pass;
  logic [1:0]        fmask;
  logic [WidthW-1:0] col_ext, col_inc, lb;
  logic              last_col, bin_row_end;
  logic [1:0]        sub;
  logic [BlkW-1:0]   blk;
  logic [PixW-1:0]   v;
  logic [SumW-1:0]   s_in, s_new;
  logic [CntW-1:0]   c_in, c_new;
  logic              add_en;
  logic [SumW-1:0]   gray;
  logic [CntW:0]     rem_sh, rem_sub;
  logic              qbit;
  logic              out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleNone;
      depth_q <= 1'b0;
      width_q <= WidthReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegScale: scale_q <= cfg_data_i[1:0];
        RegDepth: depth_q <= cfg_data_i[0];
        RegWidth: width_q <= cfg_data_i[WidthW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = WidthW'(1);
    end else if (width_q > WidthW'(MaxWidth)) begin
      eff_w = WidthW'(MaxWidth);
    end else begin
      eff_w = width_q;
    end
  end

  assign is2   = (scale_q == Scale2x2);
  assign is4   = (scale_q == Scale4x4);
  assign pass  = !is2 && !is4;
  assign fmask = is4 ? 2'b11 : (is2 ? 2'b01 : 2'b00);

  assign col_ext  = WidthW'(col_q);
  assign col_inc  = col_ext + WidthW'(1);
  assign last_col = (col_inc >= eff_w);
  assign sub      = col_q[1:0] & fmask;
  assign blk      = is4 ? {1'b0, col_q[ColW-1:2]} : col_q[ColW-1:1];
  // last column that closes a whole block
  assign lb          = eff_w & ~{{(WidthW-2){1'b0}}, fmask};
  assign bin_row_end = (lb != '0) && (col_ext == lb - WidthW'(1));
  assign v           = depth_q ? in_item_i.pixel_value : {8'h00, in_item_i.pixel_value[7:0]};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      if (pass || row_q >= fmask) begin
        row_d = '0;
      end else begin
        row_d = row_q + 2'd1;
      end
    end else begin
      col_d = col_inc[ColW-1:0];
    end
    if (in_item_i.frame_end) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.take) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // accumulate onto the stored partial of this block column
  assign s_in   = first_q ? '0 : rd_q[SumW+CntW-1:CntW];
  assign c_in   = first_q ? '0 : rd_q[CntW-1:0];
  assign add_en = !depth_q || (v_q != '0);
  assign s_new  = add_en ? s_in + SumW'(v_q) : s_in;
  assign c_new  = add_en ? c_in + CntW'(1) : c_in;
  assign gray   = is4 ? (s_new >> 4) : (s_new >> 2);

  // restoring divide, one quotient bit per step
  assign rem_sh  = {rem_q, num_q[SumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign qbit    = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      v_q       <= v;
      fend_q    <= in_item_i.frame_end;
      first_q   <= (row_q == 2'd0) && (sub == 2'd0);
      emit_q    <= (row_q == fmask) && (sub == fmask);
      row_end_q <= pass ? last_col : bin_row_end;
      blk_q     <= blk;
      res_q     <= v;
    end else if (cmd_i.calc) begin
      res_q <= depth_q ? '0 : gray[PixW-1:0];
      num_q <= s_new;
      rem_q <= '0;
      den_q <= c_new;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      num_q <= {num_q[SumW-2:0], qbit};
      res_q <= {num_q[PixW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[blk];
    if (cmd_i.calc) begin
      mem[blk_q] <= {s_new, c_new};
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_item_q.binned_value <= res_q;
      out_item_q.row_end      <= row_end_q;
      out_item_q.frame_done   <= fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign stat_o.pass     = pass;
  assign stat_o.emit     = emit_q;
  assign stat_o.need_div = depth_q && (c_new != '0);
  assign stat_o.out_free = out_free;

  a_first_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.calc && first_q) |-> (c_new <= CntW'(1)))
    else $error("first pixel of a block carries an old count");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (den_q != '0))
    else $error("divide step with zero divisor");

  // a partial sum can exceed a byte; block means cannot while the scale is held through the frame
  a_gray_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.calc && !depth_q && emit_q) |=> (res_q[PixW-1:8] == '0))
    else $error("gray block mean above 8 bits");

endmodule

// File: design/ibd_ctrl.sv
// Controller: sequences accept, store update, divide and output load per item.
`timescale 1ns / 1ps

module ibd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ibd_pkg::dp_stat_t stat_i,
  output ibd_pkg::dp_cmd_t  cmd_o
);
  import ibd_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StCalc = 4'b0010,
    StDiv  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  localparam logic [StepW-1:0] StepLast = StepW'(DivSteps - 1);

  state_e          state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = stat_i.pass ? StOut : StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        cnt_d      = '0;
        if (!stat_i.emit) begin
          state_d = StIdle;
        end else if (stat_i.need_div) begin
          state_d = StDiv;
        end else begin
          state_d = StOut;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + StepW'(1);
        if (cnt_q == StepLast) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> stat_i.out_free)
    else $error("output register overwritten while full");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q == StepLast) |=> (state_q == StOut))
    else $error("divide did not finish after its last step");

endmodule

// File: design/image_box_downscale.sv
// Top level of the streaming 2x2 / 4x4 image binning block.
//
// Pixels enter in raster order on the input channel (in_valid_i / in_stall_o,
// payload in_item_i); a transfer happens on a clock edge with valid high and
// stall low. Results leave on the output channel (out_valid_o / out_stall_i,
// payload out_item_o) from an output register, so a new pixel is taken while
// a finished result waits for the receiver.
// Configuration (scale, depth mode, row width) is written through
// cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; the user must
// write it only while idle, as the block itself does not enforce that. Per
// pixel the controller runs accept and output load (pass-through), accept
// and store update (binned pixel that closes no block), or accept, store
// update and output load (gray block result); a depth block result adds a
// 20-step one bit per cycle divide before the output load unless no sample
// is valid. The line store is read in one cycle and written in the next, so
// each binned pixel makes a read-modify-write of its block column entry.
// Reset clears the configuration to pass-through, gray, width 640, and the
// position counters; the line store needs no clearing, since the first row
// of every band overwrites it. When the receiver stalls, the held result
// stays put and the block stops taking pixels once the next result is ready.
`timescale 1ns / 1ps

module image_box_downscale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ibd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ibd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ibd_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ibd_pkg::out_item_t           out_item_o
);
  import ibd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ibd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ibd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
